// File: design/steq_pkg.sv
// Shared types and codes for the sorted tick event queue.
// No dependencies; imported by the cell and the top level.
`default_nettype none

package steq_pkg;

   localparam int ID_WIDTH     = 4;
   localparam int STATUS_WIDTH = 2;
   localparam int COUNT_FIELD  = 5;
   localparam int TICK_FIELD   = 32;

   // request kinds
   localparam logic REQ_INSERT = 1'b0;
   localparam logic REQ_REMOVE = 1'b1;

   // result status codes
   localparam logic [STATUS_WIDTH-1:0] STATUS_DONE = 2'd0;
   localparam logic [STATUS_WIDTH-1:0] STATUS_FULL = 2'd1;
   localparam logic [STATUS_WIDTH-1:0] STATUS_MISS = 2'd2;

   // operation broadcast along the cell chain
   typedef enum logic [1:0] {
      CHAIN_HOLD,
      CHAIN_REMOVE,
      CHAIN_INSERT
   } chain_mode_type;

   typedef struct packed {
      chain_mode_type        mode;
      logic [ID_WIDTH-1:0]   id;
   } chain_ctrl_type;

endpackage

`default_nettype wire

// File: design/steq_if.sv
// Handshake interfaces for the request and result channels.
// Depends on steq_pkg for field widths.
`default_nettype none

interface steq_req_if import steq_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic                  req_type;
   logic [ID_WIDTH-1:0]   event_id;
   logic [TICK_FIELD-1:0] due_tick;

   modport source (output valid, req_type, event_id, due_tick, input ready);
   modport sink   (input valid, req_type, event_id, due_tick, output ready);
endinterface

interface steq_rsp_if import steq_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [STATUS_WIDTH-1:0] status;
   logic                    head_valid;
   logic [ID_WIDTH-1:0]     head_id;
   logic [TICK_FIELD-1:0]   head_tick;
   logic [COUNT_FIELD-1:0]  queue_count;

   modport source (output valid, status, head_valid, head_id, head_tick, queue_count,
                   input ready);
   modport sink   (input valid, status, head_valid, head_id, head_tick, queue_count,
                   output ready);
endinterface

`default_nettype wire

// File: design/steq_cell.sv
// One slot of the sorted chain: holds an entry and shifts to/from neighbours.
// Depends on steq_pkg for the chain control struct.
`default_nettype none

module steq_cell import steq_pkg::*; #(
   parameter int TICK_WIDTH = 32
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire chain_ctrl_type        ctrl,
   input  wire logic [TICK_WIDTH-1:0] new_tick,
   input  wire logic                  left_valid,
   input  wire logic [TICK_WIDTH-1:0] left_tick,
   input  wire logic [ID_WIDTH-1:0]   left_id,
   input  wire logic                  right_valid,
   input  wire logic [TICK_WIDTH-1:0] right_tick,
   input  wire logic [ID_WIDTH-1:0]   right_id,
   input  wire logic                  carry_in,
   output logic                       carry_out,
   output logic                       valid_out,
   output logic [TICK_WIDTH-1:0]      tick_out,
   output logic [ID_WIDTH-1:0]        id_out
);

   logic                  valid_ff, valid_in;
   logic [TICK_WIDTH-1:0] tick_ff, tick_in;
   logic [ID_WIDTH-1:0]   id_ff, id_in;
   logic [TICK_WIDTH-1:0] diff;
   logic                  later;
   logic                  hit;

   // stored tick strictly later than the new one, wrapping difference
   assign diff  = tick_ff - new_tick;
   assign later = (diff != '0) && !diff[TICK_WIDTH-1];

   // local hit: owner match on remove, insertion point on insert
   always_comb begin
      case (ctrl.mode)
         CHAIN_REMOVE: hit = valid_ff && (id_ff == ctrl.id);
         CHAIN_INSERT: hit = !valid_ff || later;
         default:      hit = 1'b0;
      endcase
   end

   assign carry_out = carry_in | hit;

   // next entry: shift left after the removed slot, right after the insert point
   always_comb begin
      valid_in = valid_ff;
      tick_in  = tick_ff;
      id_in    = id_ff;
      case (ctrl.mode)
         CHAIN_REMOVE: begin
            if (carry_out) begin
               valid_in = right_valid;
               tick_in  = right_tick;
               id_in    = right_id;
            end
         end
         CHAIN_INSERT: begin
            if (carry_in) begin
               valid_in = left_valid;
               tick_in  = left_tick;
               id_in    = left_id;
            end else if (hit) begin
               valid_in = 1'b1;
               tick_in  = new_tick;
               id_in    = ctrl.id;
            end
         end
         default: begin
            valid_in = valid_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // payload needs no reset
   always_ff @(posedge clock) begin
      tick_ff <= tick_in;
      id_ff   <= id_in;
   end

   assign valid_out = valid_ff;
   assign tick_out  = tick_ff;
   assign id_out    = id_ff;

endmodule

`default_nettype wire

// File: design/sorted_tick_event_queue.sv
// Top level of the sorted tick event queue: sequencer and chain of cells.
// Depends on steq_pkg, steq_if and steq_cell.
//
//   channel   dir   carries                                          handshake
//   req_chan  in    req_type, event_id, due_tick                     valid/ready
//   rsp_chan  out   status, head_valid, head_id, head_tick, count    valid/ready
//
// A request passes through four steps: capture, a removal pass over the cell chain,
// an insertion pass, and loading of the result register; one request is in
// work at a time, so a new request is taken only after the last result is loaded.
// Reset is synchronous and clears the cell valid bits, the count and the
// sequencer. A stalled result holds in its register; the sequencer waits
// in its final step until that register is free.
`default_nettype none

module sorted_tick_event_queue import steq_pkg::*; #(
   parameter int MAX_EVENTS = 16,
   parameter int TICK_WIDTH = 32
) (
   input  wire logic   clock,
   input  wire logic   reset,
   steq_req_if.sink    req_chan,
   steq_rsp_if.source  rsp_chan
);

   localparam int CNT_W = $clog2(MAX_EVENTS + 1);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_REMOVE,
      ST_INSERT,
      ST_EMIT
   } state_type;

   state_type                state_ff;
   logic                     kind_ff;
   logic [ID_WIDTH-1:0]      id_ff;
   logic [TICK_WIDTH-1:0]    tick_ff, tick_in;
   logic [STATUS_WIDTH-1:0]  status_ff;
   logic [CNT_W-1:0]         count_ff;

   logic                     rsp_valid_ff;
   logic [STATUS_WIDTH-1:0]  rsp_status_ff;
   logic                     rsp_head_valid_ff;
   logic [ID_WIDTH-1:0]      rsp_head_id_ff;
   logic [TICK_FIELD-1:0]    rsp_head_tick_ff, head_tick_in;
   logic [COUNT_FIELD-1:0]   rsp_count_ff, count_field_in;

   chain_ctrl_type           ctrl;
   logic                     accept;
   logic                     found;
   logic                     full;
   logic                     out_free;

   logic [MAX_EVENTS-1:0]    cell_valid;
   logic [TICK_WIDTH-1:0]    cell_tick [MAX_EVENTS];
   logic [ID_WIDTH-1:0]      cell_id   [MAX_EVENTS];
   logic [MAX_EVENTS:0]      carry;

   // field width adaption
   generate
      if (TICK_WIDTH > TICK_FIELD) begin : g_tick_wide
         assign tick_in = {{(TICK_WIDTH - TICK_FIELD){1'b0}}, req_chan.due_tick};
      end else begin : g_tick_narrow
         assign tick_in = req_chan.due_tick[TICK_WIDTH-1:0];
      end
      if (TICK_WIDTH >= TICK_FIELD) begin : g_head_wide
         assign head_tick_in = cell_tick[0][TICK_FIELD-1:0];
      end else begin : g_head_narrow
         assign head_tick_in = {{(TICK_FIELD - TICK_WIDTH){1'b0}}, cell_tick[0]};
      end
      if (CNT_W >= COUNT_FIELD) begin : g_cnt_wide
         assign count_field_in = count_ff[COUNT_FIELD-1:0];
      end else begin : g_cnt_narrow
         assign count_field_in = {{(COUNT_FIELD - CNT_W){1'b0}}, count_ff};
      end
   endgenerate

   assign accept   = req_chan.valid && req_chan.ready;
   assign found    = carry[MAX_EVENTS];
   assign full     = (count_ff == CNT_W'(MAX_EVENTS));
   assign out_free = !rsp_valid_ff || rsp_chan.ready;

   // chain operation for the current step
   always_comb begin
      ctrl.id = id_ff;
      case (state_ff)
         ST_REMOVE: ctrl.mode = CHAIN_REMOVE;
         ST_INSERT: ctrl.mode = (kind_ff == REQ_INSERT && !full) ? CHAIN_INSERT : CHAIN_HOLD;
         default:   ctrl.mode = CHAIN_HOLD;
      endcase
   end

   // chain of cells with neighbour links
   assign carry[0] = 1'b0;
   generate
      for (genvar i = 0; i < MAX_EVENTS; i++) begin : g_cell
         logic                  lv, rv;
         logic [TICK_WIDTH-1:0] lt, rt;
         logic [ID_WIDTH-1:0]   li, ri;
         if (i == 0) begin : g_first
            assign lv = 1'b0;
            assign lt = '0;
            assign li = '0;
         end else begin : g_mid_l
            assign lv = cell_valid[i-1];
            assign lt = cell_tick[i-1];
            assign li = cell_id[i-1];
         end
         if (i == MAX_EVENTS - 1) begin : g_last
            assign rv = 1'b0;
            assign rt = '0;
            assign ri = '0;
         end else begin : g_mid_r
            assign rv = cell_valid[i+1];
            assign rt = cell_tick[i+1];
            assign ri = cell_id[i+1];
         end
         steq_cell #(
            .TICK_WIDTH (TICK_WIDTH)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl),
            .new_tick    (tick_ff),
            .left_valid  (lv),
            .left_tick   (lt),
            .left_id     (li),
            .right_valid (rv),
            .right_tick  (rt),
            .right_id    (ri),
            .carry_in    (carry[i]),
            .carry_out   (carry[i+1]),
            .valid_out   (cell_valid[i]),
            .tick_out    (cell_tick[i]),
            .id_out      (cell_id[i])
         );
      end
   endgenerate

   // sequencer, count and result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (state_ff == ST_EMIT && out_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  kind_ff   <= req_chan.req_type;
                  id_ff     <= req_chan.event_id;
                  tick_ff   <= tick_in;
                  status_ff <= STATUS_DONE;
                  state_ff  <= ST_REMOVE;
               end
            end
            ST_REMOVE: begin
               if (found) begin
                  count_ff <= count_ff - CNT_W'(1);
               end else if (kind_ff == REQ_REMOVE) begin
                  status_ff <= STATUS_MISS;
               end
               state_ff <= ST_INSERT;
            end
            ST_INSERT: begin
               if (kind_ff == REQ_INSERT) begin
                  if (full) begin
                     status_ff <= STATUS_FULL;
                  end else begin
                     count_ff <= count_ff + CNT_W'(1);
                  end
               end
               state_ff <= ST_EMIT;
            end
            ST_EMIT: begin
               if (out_free) begin
                  rsp_status_ff     <= status_ff;
                  rsp_head_valid_ff <= cell_valid[0];
                  rsp_head_id_ff    <= cell_valid[0] ? cell_id[0] : '0;
                  rsp_head_tick_ff  <= cell_valid[0] ? head_tick_in : '0;
                  rsp_count_ff      <= count_field_in;
                  state_ff          <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_chan.ready       = (state_ff == ST_IDLE);
   assign rsp_chan.valid       = rsp_valid_ff;
   assign rsp_chan.status      = rsp_status_ff;
   assign rsp_chan.head_valid  = rsp_head_valid_ff;
   assign rsp_chan.head_id     = rsp_head_id_ff;
   assign rsp_chan.head_tick   = rsp_head_tick_ff;
   assign rsp_chan.queue_count = rsp_count_ff;

   // count stays within capacity
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(MAX_EVENTS))
      else $error("queue count above capacity");

   // head cell occupancy agrees with the count outside a pass
   a_head_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_EMIT) |-> (cell_valid[0] == (count_ff != '0)))
      else $error("head cell valid disagrees with count");

   // last cell occupied only when the queue is full
   a_last_full: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_IDLE || state_ff == ST_EMIT) |-> (!cell_valid[MAX_EVENTS-1] || full))
      else $error("cells not packed at the front");

   // a blocked result keeps the sequencer waiting
   a_emit_wait: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EMIT && !out_free) |=> (state_ff == ST_EMIT))
      else $error("result register overwritten");

endmodule

`default_nettype wire

// File: bench/steq_order_checker.sv
// Checker for the sorted tick event queue: watches both channels, keeps its own
// sorted copy of the queue and compares every result with the predicted one.
// Depends on steq_pkg for field widths, request kinds and status codes.

module steq_order_checker import steq_pkg::*; #(
   parameter int MAX_EVENTS = 16
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic                    req_ready,
   input  logic                    req_type,
   input  logic [ID_WIDTH-1:0]     req_event_id,
   input  logic [TICK_FIELD-1:0]   req_due_tick,
   input  logic                    rsp_valid,
   input  logic                    rsp_ready,
   input  logic [STATUS_WIDTH-1:0] rsp_status,
   input  logic                    rsp_head_valid,
   input  logic [ID_WIDTH-1:0]     rsp_head_id,
   input  logic [TICK_FIELD-1:0]   rsp_head_tick,
   input  logic [COUNT_FIELD-1:0]  rsp_queue_count,
   output int unsigned             mismatch_count,
   output int unsigned             results_owed
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      logic [STATUS_WIDTH-1:0] status;
      logic                    head_valid;
      logic [ID_WIDTH-1:0]     head_id;
      logic [TICK_FIELD-1:0]   head_tick;
      logic [COUNT_FIELD-1:0]  queue_count;
   } queue_view_type;

   // predicted queue contents, earliest due tick first
   logic [TICK_FIELD-1:0] slot_due [MAX_EVENTS];
   logic [ID_WIDTH-1:0]   slot_id  [MAX_EVENTS];
   int                    fill = 0;
   bit                    id_present [1 << ID_WIDTH];

   queue_view_type owed_q [$];
   int unsigned    mismatches = 0;

   // a is strictly later than b when the wrapped difference is non-zero and positive
   function automatic bit due_after(input logic [TICK_FIELD-1:0] a,
                                    input logic [TICK_FIELD-1:0] b);
      logic [TICK_FIELD-1:0] diff;
      diff = a - b;
      return (diff != '0) && !diff[TICK_FIELD-1];
   endfunction

   // take an id out of the sorted list and close the gap
   function automatic void unlink(input logic [ID_WIDTH-1:0] id);
      int pos;
      pos = fill;
      for (int i = 0; i < fill; i++)
         if (pos == fill && slot_id[i] == id) pos = i;
      if (pos < fill) begin
         for (int i = pos; i + 1 < fill; i++) begin
            slot_due[i] = slot_due[i + 1];
            slot_id[i]  = slot_id[i + 1];
         end
         fill--;
      end
      id_present[id] = 1'b0;
   endfunction

   // apply one request to the predicted queue and return the view it leaves
   function automatic queue_view_type apply_request(input logic kind,
                                                    input logic [ID_WIDTH-1:0] id,
                                                    input logic [TICK_FIELD-1:0] tick);
      queue_view_type view;
      int             pos;
      view        = '0;
      view.status = STATUS_DONE;
      if (kind == REQ_INSERT) begin
         // a reschedule drops the old entry first
         if (id_present[id]) unlink(id);
         if (fill >= MAX_EVENTS) begin
            view.status = STATUS_FULL;
         end else begin
            // goes after every entry that is not later, so equal ticks stay in order
            pos = fill;
            for (int i = 0; i < fill; i++)
               if (pos == fill && due_after(slot_due[i], tick)) pos = i;
            for (int i = fill; i > pos; i--) begin
               slot_due[i] = slot_due[i - 1];
               slot_id[i]  = slot_id[i - 1];
            end
            slot_due[pos]  = tick;
            slot_id[pos]   = id;
            fill++;
            id_present[id] = 1'b1;
         end
      end else if (id_present[id]) begin
         unlink(id);
      end else begin
         view.status = STATUS_MISS;
      end
      if (fill > 0) begin
         view.head_valid = 1'b1;
         view.head_id    = slot_id[0];
         view.head_tick  = slot_due[0];
      end
      view.queue_count = COUNT_FIELD'(fill);
      return view;
   endfunction

   task automatic check_field(input string what, input logic [TICK_FIELD-1:0] want,
                              input logic [TICK_FIELD-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
         mismatches++;
      end
   endtask

   // request first, then result: the block never answers a request in its own cycle
   always @(posedge clock) begin : watch
      queue_view_type want;
      if (reset) begin
         fill = 0;
         foreach (id_present[i]) id_present[i] = 1'b0;
         owed_q.delete();
      end else begin
         if (req_valid && req_ready)
            owed_q.push_back(apply_request(req_type, req_event_id, req_due_tick));
         if (rsp_valid && rsp_ready) begin
            if (owed_q.size() == 0) begin
               $display("%0t: result with nothing expected, expected none, actual status %0h",
                        $time, rsp_status);
               mismatches++;
            end else begin
               want = owed_q.pop_front();
               check_field("status", TICK_FIELD'(want.status), TICK_FIELD'(rsp_status));
               check_field("head_valid", TICK_FIELD'(want.head_valid),
                           TICK_FIELD'(rsp_head_valid));
               check_field("head_id", TICK_FIELD'(want.head_id), TICK_FIELD'(rsp_head_id));
               check_field("head_tick", want.head_tick, rsp_head_tick);
               check_field("queue_count", TICK_FIELD'(want.queue_count),
                           TICK_FIELD'(rsp_queue_count));
            end
         end
      end
      mismatch_count <= mismatches;
      results_owed   <= owed_q.size();
   end

endmodule

// File: bench/tb.sv
// Top of the sorted tick event queue bench: clock, reset, request and result traffic.
// Depends on steq_pkg, steq_if, sorted_tick_event_queue and steq_order_checker.

module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import steq_pkg::*;

   logic        clock = 1'b0;
   logic        reset;
   bit          sender_calm = 1'b0;
   int unsigned mismatch_count;
   int unsigned results_owed;

   steq_req_if req_chan ();
   steq_rsp_if rsp_chan ();

   sorted_tick_event_queue i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   steq_order_checker i_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_chan.valid),
      .req_ready       (req_chan.ready),
      .req_type        (req_chan.req_type),
      .req_event_id    (req_chan.event_id),
      .req_due_tick    (req_chan.due_tick),
      .rsp_valid       (rsp_chan.valid),
      .rsp_ready       (rsp_chan.ready),
      .rsp_status      (rsp_chan.status),
      .rsp_head_valid  (rsp_chan.head_valid),
      .rsp_head_id     (rsp_chan.head_id),
      .rsp_head_tick   (rsp_chan.head_tick),
      .rsp_queue_count (rsp_chan.queue_count),
      .mismatch_count  (mismatch_count),
      .results_owed    (results_owed)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // offer one request after a random gap and return at the edge that takes it
   task automatic offer(input logic kind, input logic [ID_WIDTH-1:0] id,
                        input logic [TICK_FIELD-1:0] tick);
      int gap;
      gap = sender_calm ? 0 : $urandom_range(0, 15);
      if (gap > 0) begin
         if (req_chan.valid) req_chan.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.req_type <= kind;
      req_chan.event_id <= id;
      req_chan.due_tick <= tick;
      do @(posedge clock); while (!req_chan.ready);
   endtask

   // request stimulus and verdict
   initial begin : stimulus
      logic                  kind;
      logic [ID_WIDTH-1:0]   id;
      logic [TICK_FIELD-1:0] tick;
      logic [TICK_FIELD-1:0] tick_base;
      int                    insert_pct;
      reset             <= 1'b1;
      req_chan.valid    <= 1'b0;
      req_chan.req_type <= REQ_INSERT;
      req_chan.event_id <= '0;
      req_chan.due_tick <= '0;
      insert_pct = 60;
      tick_base  = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed: empty queue, wrap-around ordering, ties, reschedule, full queue
      offer(REQ_REMOVE, 4'd3, 32'h0000_0000);
      offer(REQ_INSERT, 4'd0, 32'hFFFF_FFF0);
      offer(REQ_INSERT, 4'd1, 32'h0000_0010);
      offer(REQ_INSERT, 4'd2, 32'hFFFF_FFF0);
      offer(REQ_INSERT, 4'd3, 32'h7FFF_FFF0);   // exactly half the tick range away
      offer(REQ_INSERT, 4'd15, 32'hFFFF_FFFF);
      offer(REQ_INSERT, 4'd4, 32'h0000_0000);
      offer(REQ_INSERT, 4'd0, 32'h0000_0020);
      offer(REQ_REMOVE, 4'd2, 32'hFFFF_FFFF);
      offer(REQ_REMOVE, 4'd2, 32'h0000_0000);
      offer(REQ_REMOVE, 4'd15, 32'h5555_AAAA);
      for (int slot = 2; slot < 16; slot++)
         if (slot != 3 && slot != 4)
            offer(REQ_INSERT, ID_WIDTH'(slot), 32'h0000_0010 + slot % 3);
      offer(REQ_INSERT, 4'd7, 32'h0000_0000);   // reschedule while full
      offer(REQ_REMOVE, 4'd7, 32'hAAAA_5555);

      // random: phases biased towards filling or draining, ticks clustered
      for (int n = 0; n < 850; n++) begin
         if (n % 40 == 0) begin
            case ($urandom_range(0, 2))
               0: insert_pct = 90;
               1: insert_pct = 60;
               default: insert_pct = 25;
            endcase
            tick_base = ($urandom_range(0, 3) == 0) ? 32'hFFFF_FFF8 : $urandom();
         end
         if (n % 60 == 0) sender_calm = ($urandom_range(0, 2) == 0);
         // let the queue drain completely once
         if (n == 425) begin
            req_chan.valid <= 1'b0;
            do @(posedge clock); while (results_owed != 0);
         end
         kind = ($urandom_range(1, 100) <= insert_pct) ? REQ_INSERT : REQ_REMOVE;
         id   = ID_WIDTH'($urandom_range(0, 15));
         case ($urandom_range(0, 7))
            0: tick = $urandom();
            1: tick = tick_base ^ 32'h8000_0000;
            default: tick = tick_base + $urandom_range(0, 12) - 6;
         endcase
         offer(kind, id, tick);
      end
      req_chan.valid <= 1'b0;

      do @(posedge clock); while (results_owed != 0);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && results_owed == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // result side: random stalls, calm stretches and one long hold-off
   initial begin : receiver
      int gap;
      int taken;
      bit calm;
      rsp_chan.ready <= 1'b0;
      taken = 0;
      calm  = 1'b0;
      do @(posedge clock); while (reset !== 1'b0);
      forever begin
         if (taken % 50 == 0) calm = ($urandom_range(0, 2) == 0);
         gap = calm ? 0 : $urandom_range(0, 15);
         if (taken == 300) gap = 400;
         if (gap > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         taken++;
      end
   end

   // watchdog
   initial begin : watchdog
      #5_000_000;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
